// ===== hdl/nkg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkg_pkg: shared types and constants of the keyframe gate
// Codec codes, NAL type numbers and the per-packet summary word that moves
// from the byte scanner to the gate decision through the summary queue.
// ----------------------------------------------------------------------------
package nkg_pkg;

    // codec_kind register codes
    localparam logic [1:0] CODEC_NONE  = 2'd0;
    localparam logic [1:0] CODEC_OTHER = 2'd1;
    localparam logic [1:0] CODEC_H264  = 2'd2;
    localparam logic [1:0] CODEC_HEVC  = 2'd3;

    // H.264 NAL unit types (5-bit field)
    localparam logic [4:0] H264_TYPE_MASK = 5'h1F;
    localparam logic [4:0] H264_SPS       = 5'd7;
    localparam logic [4:0] H264_PPS       = 5'd8;
    localparam logic [4:0] H264_IDR       = 5'd5;

    // HEVC NAL unit types (6-bit field)
    localparam logic [5:0] HEVC_TYPE_MASK = 6'h3F;
    localparam logic [5:0] HEVC_SPS       = 6'd33;
    localparam logic [5:0] HEVC_PPS       = 6'd34;
    localparam logic [5:0] HEVC_IRAP_LO   = 6'd16;
    localparam logic [5:0] HEVC_IRAP_HI   = 6'd21;

    // start code prefix
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

    // default depth of the summary queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // one packet summary, written on the last byte of a packet
    typedef struct packed {
        logic pass_all;   // codec_kind was "no decoder"
        logic keyframe;   // IDR/IRAP unit found or key flag set
        logic sps;        // sticky SPS flag after this packet
        logic pps;        // sticky PPS flag after this packet
    } pkt_sum_t;

endpackage : nkg_pkg
`default_nettype wire

// ===== hdl/nal_keyframe_gate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nal_keyframe_gate: start-of-decode gate for Annex B video packets
// Scans packet bytes for start codes, classifies NAL headers and reports per
// packet whether it may pass to the decoder.
//
//   Channel   Handshake             Words
//   in        in_valid/in_ready     data_byte, last, key_flag (one byte)
//   out       out_valid/out_ready   keep, has_keyframe, sps_seen, pps_seen,
//                                   still_waiting (one per packet)
//   cfg       cfg_valid/cfg_ready   cfg_data = codec_kind
//
// One byte is taken every cycle; the scanner does all byte work in the
// accepting cycle. A packet result is registered first in the summary queue
// and then in the result register. The input stalls only when the
// summary queue (QUEUE_DEPTH entries) is full behind a stalled output.
// Reset: codec_kind none, gate waiting, no parameter sets seen; no clearing
// pass. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module nal_keyframe_gate #(
    parameter int QUEUE_DEPTH = nkg_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [1:0]  cfg_data,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire [7:0]  data_byte,
    input  wire        last,
    input  wire        key_flag,
    output logic       out_valid,
    input  wire        out_ready,
    output logic       keep,
    output logic       has_keyframe,
    output logic       sps_seen,
    output logic       pps_seen,
    output logic       still_waiting
);
    import nkg_pkg::*;

    logic [1:0] codec_kind_reg;
    pkt_sum_t   push_data;
    pkt_sum_t   pop_data;
    logic       sum_push;
    logic       sum_pop;
    logic       sum_full;
    logic       sum_empty;

    // hold the codec register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            codec_kind_reg <= CODEC_NONE;
        else if (cfg_valid && cfg_ready)
            codec_kind_reg <= cfg_data;
    end

    nkg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .codec_kind (codec_kind_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last       (last),
        .key_flag   (key_flag),
        .sum_full   (sum_full),
        .sum_push   (sum_push),
        .sum_data   (push_data)
    );

    nkg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sum_push),
        .push_data (push_data),
        .full      (sum_full),
        .pop       (sum_pop),
        .pop_data  (pop_data),
        .empty     (sum_empty)
    );

    nkg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .sum_empty     (sum_empty),
        .sum_pop       (sum_pop),
        .sum_data      (pop_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .keep          (keep),
        .has_keyframe  (has_keyframe),
        .sps_seen      (sps_seen),
        .pps_seen      (pps_seen),
        .still_waiting (still_waiting)
    );

endmodule : nal_keyframe_gate
`default_nettype wire

// ===== hdl/nkg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkg_front: byte scanner and NAL header classifier
// Tracks Annex B start codes, classifies the header byte after each one,
// keeps the sticky SPS/PPS flags and writes one summary per packet.
// ----------------------------------------------------------------------------
module nkg_front (
    input  wire              clk,
    input  wire              rst_n,
    input  wire [1:0]        codec_kind,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire [7:0]        data_byte,
    input  wire              last,
    input  wire              key_flag,
    input  wire              sum_full,
    output logic             sum_push,
    output nkg_pkg::pkt_sum_t sum_data
);
    import nkg_pkg::*;

    logic [1:0] zero_run_reg,    zero_run_next;
    logic       header_next_reg, header_next_next;
    logic       packet_idr_reg,  packet_idr_next;
    logic       seen_sps_reg,    seen_sps_next;
    logic       seen_pps_reg,    seen_pps_next;

    logic       accept;
    logic       start;
    logic       hit_sps;
    logic       hit_pps;
    logic       hit_idr;
    logic [4:0] h264_type;
    logic [5:0] hevc_type;

    // stall only when the summary queue has no room
    assign in_ready = !sum_full;
    assign accept   = in_valid && in_ready;

    assign h264_type = data_byte[4:0] & H264_TYPE_MASK;
    assign hevc_type = data_byte[6:1] & HEVC_TYPE_MASK;

    // classify a header byte with the current codec
    always_comb
    begin
        hit_sps = 1'b0;
        hit_pps = 1'b0;
        hit_idr = 1'b0;
        if (header_next_reg)
        begin
            unique case (codec_kind)
                CODEC_H264:
                begin
                    hit_sps = (h264_type == H264_SPS);
                    hit_pps = (h264_type == H264_PPS);
                    hit_idr = (h264_type == H264_IDR);
                end
                CODEC_HEVC:
                begin
                    hit_sps = (hevc_type == HEVC_SPS);
                    hit_pps = (hevc_type == HEVC_PPS);
                    hit_idr = (hevc_type >= HEVC_IRAP_LO) && (hevc_type <= HEVC_IRAP_HI);
                end
                CODEC_NONE,
                CODEC_OTHER:
                begin
                    hit_sps = 1'b0;
                    hit_pps = 1'b0;
                    hit_idr = 1'b0;
                end
                default:
                begin
                    hit_sps = 1'b0;
                    hit_pps = 1'b0;
                    hit_idr = 1'b0;
                end
            endcase
        end
    end

    assign start = (data_byte == BYTE_ONE) && (zero_run_reg == ZERO_RUN_MAX);

    // advance scan state on each accepted word unless codec_kind is none
    always_comb
    begin
        zero_run_next    = zero_run_reg;
        header_next_next = header_next_reg;
        packet_idr_next  = packet_idr_reg;
        seen_sps_next    = seen_sps_reg;
        seen_pps_next    = seen_pps_reg;
        if (accept && (codec_kind != CODEC_NONE))
        begin
            seen_sps_next    = seen_sps_reg   || hit_sps;
            seen_pps_next    = seen_pps_reg   || hit_pps;
            packet_idr_next  = packet_idr_reg || hit_idr;
            header_next_next = start;
            if (data_byte == BYTE_ZERO)
            begin
                if (zero_run_reg != ZERO_RUN_MAX)
                    zero_run_next = zero_run_reg + 2'd1;
            end
            else
            begin
                zero_run_next = 2'd0;
            end
        end
        // start codes never span packets
        if (accept && last)
        begin
            zero_run_next    = 2'd0;
            header_next_next = 1'b0;
            packet_idr_next  = 1'b0;
        end
    end

    // write the packet summary on the last word
    assign sum_push          = accept && last;
    assign sum_data.pass_all = (codec_kind == CODEC_NONE);
    assign sum_data.keyframe = (codec_kind == CODEC_NONE) ? key_flag
                             : ((packet_idr_reg || hit_idr) || key_flag);
    assign sum_data.sps      = seen_sps_next;
    assign sum_data.pps      = seen_pps_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg    <= 2'd0;
            header_next_reg <= 1'b0;
            packet_idr_reg  <= 1'b0;
            seen_sps_reg    <= 1'b0;
            seen_pps_reg    <= 1'b0;
        end
        else
        begin
            zero_run_reg    <= zero_run_next;
            header_next_reg <= header_next_next;
            packet_idr_reg  <= packet_idr_next;
            seen_sps_reg    <= seen_sps_next;
            seen_pps_reg    <= seen_pps_next;
        end
    end

    // zero run saturates at two
    a_zero_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
        zero_run_reg != 2'd3)
        else $error("zero run beyond saturation");

    // packet state clears after a last word
    a_pkt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (zero_run_reg == 2'd0) && !header_next_reg && !packet_idr_reg)
        else $error("packet state not cleared after last word");

    // a header byte is expected only right after a 00 00 01 prefix
    a_header_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(header_next_reg) |-> $past(start && accept))
        else $error("header flag set without start code");

endmodule : nkg_front
`default_nettype wire

// ===== hdl/nkg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkg_queue: packet summary queue
// Small register FIFO that decouples the scanner from the gate decision.
// ----------------------------------------------------------------------------
module nkg_queue #(
    parameter int DEPTH = nkg_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  nkg_pkg::pkt_sum_t push_data,
    output logic              full,
    input  wire               pop,
    output nkg_pkg::pkt_sum_t pop_data,
    output logic              empty
);
    import nkg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pkt_sum_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the written summary
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // never overfill
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("summary queue count beyond depth");

    // a push into a full queue would lose a packet
    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("summary pushed into full queue");

    // pointers stay consistent with the count
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule : nkg_queue
`default_nettype wire

// ===== hdl/nkg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkg_back: gate decision and result register
// Takes packet summaries in order, updates the waiting flag and holds one
// result word until the consumer takes it.
// ----------------------------------------------------------------------------
module nkg_back (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               sum_empty,
    output logic              sum_pop,
    input  nkg_pkg::pkt_sum_t sum_data,
    output logic              out_valid,
    input  wire               out_ready,
    output logic              keep,
    output logic              has_keyframe,
    output logic              sps_seen,
    output logic              pps_seen,
    output logic              still_waiting
);
    import nkg_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic waiting_reg,   waiting_next;
    logic keep_reg;
    logic keyframe_reg;
    logic sps_reg;
    logic pps_reg;
    logic waiting_out_reg;
    logic gate_open;

    // take a summary when the result register is free or being drained
    assign sum_pop = !sum_empty && (!out_valid_reg || out_ready);

    // stop waiting once SPS, PPS and a keyframe are all present and codec_kind is not none
    assign gate_open = !sum_data.pass_all && sum_data.keyframe && sum_data.sps && sum_data.pps;

    always_comb
    begin
        waiting_next   = waiting_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (sum_pop)
        begin
            out_valid_next = 1'b1;
            if (gate_open)
                waiting_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            waiting_reg   <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            waiting_reg   <= waiting_next;
        end
    end

    // load the result word
    always_ff @(posedge clk)
    begin
        if (sum_pop)
        begin
            keep_reg        <= sum_data.pass_all || !waiting_next;
            keyframe_reg    <= sum_data.keyframe;
            sps_reg         <= sum_data.sps;
            pps_reg         <= sum_data.pps;
            waiting_out_reg <= waiting_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign keep          = keep_reg;
    assign has_keyframe  = keyframe_reg;
    assign sps_seen      = sps_reg;
    assign pps_seen      = pps_reg;
    assign still_waiting = waiting_out_reg;

    // once open, the gate never closes again
    a_waiting_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(waiting_reg))
        else $error("gate returned to waiting");

    // a dropped packet means the gate is still waiting
    a_drop_means_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !keep_reg) |-> waiting_out_reg)
        else $error("packet dropped with gate open");

    // opening the gate needs both parameter sets
    a_open_needs_sets: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(waiting_reg) |-> (sps_reg && pps_reg && keyframe_reg))
        else $error("gate opened without SPS, PPS and keyframe");

endmodule : nkg_back
`default_nettype wire
